/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg - shared types and constants for the double-ended queue
// Field widths, action and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEF = 32;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam action_t ACT_PUSH_FRONT = 3'd0;
  localparam action_t ACT_PUSH_BACK  = 3'd1;
  localparam action_t ACT_POP_FRONT  = 3'd2;
  localparam action_t ACT_POP_BACK   = 3'd3;
  localparam action_t ACT_DUMP       = 3'd4;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic    push_front;
    logic    push_back;
    logic    pop_front;
    logic    pop_back;
    logic    dump_start;
    logic    dump_read;
    logic    dump_step;
    logic    load_out;
    logic    use_data;
    logic    out_last;
    status_t out_status;
  } dq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
    logic dump_last;
  } dq_stat_t;

endpackage

/* sv/dq_in_if.sv */
// ----------------------------------------------------------------------------
// dq_in_if - request channel of the double-ended queue
// Carries one action word with its push value under a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic                              valid;
  logic                              ready;
  dq_pkg::action_t                   action;
  logic signed [dq_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

/* sv/dq_out_if.sv */
// ----------------------------------------------------------------------------
// dq_out_if - result channel of the double-ended queue
// Carries one result word (status, value, last flag, count) under valid/ready.
// ----------------------------------------------------------------------------
interface dq_out_if;
  logic                              valid;
  logic                              ready;
  dq_pkg::status_t                   status;
  logic signed [dq_pkg::VALUE_W-1:0] value_res;
  logic                              last;
  logic [dq_pkg::COUNT_W-1:0]        count;

  modport source (output valid, status, value_res, last, count, input ready);
  modport sink   (input valid, status, value_res, last, count, output ready);
endinterface

/* sv/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl - sequencing state machine of the double-ended queue
// Decodes the action, issues datapath commands and steps through dumps.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  dq_pkg::action_t  in_action,
  output logic             in_ready,
  input  dq_pkg::dq_stat_t stat,
  output dq_pkg::dq_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STAT = 3'd1;
  localparam logic [2:0] S_POUT = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_DOUT = 3'd4;

  logic [2:0]      state_r, state_nxt;
  dq_pkg::status_t stat_code_r, stat_code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stat_code_r <= dq_pkg::ST_OK;
    end else begin
      state_r     <= state_nxt;
      stat_code_r <= stat_code_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    stat_code_nxt = stat_code_r;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_action)
            dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
              state_nxt = S_STAT;
              if (stat.full) begin
                stat_code_nxt = dq_pkg::ST_FULL;
              end else begin
                stat_code_nxt  = dq_pkg::ST_OK;
                cmd.push_front = (in_action == dq_pkg::ACT_PUSH_FRONT);
                cmd.push_back  = (in_action == dq_pkg::ACT_PUSH_BACK);
              end
            end
            dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
              if (stat.empty) begin
                stat_code_nxt = dq_pkg::ST_EMPTY;
                state_nxt     = S_STAT;
              end else begin
                cmd.pop_front = (in_action == dq_pkg::ACT_POP_FRONT);
                cmd.pop_back  = (in_action == dq_pkg::ACT_POP_BACK);
                state_nxt     = S_POUT;
              end
            end
            dq_pkg::ACT_DUMP: begin
              if (stat.empty) begin
                stat_code_nxt = dq_pkg::ST_EMPTY;
                state_nxt     = S_STAT;
              end else begin
                cmd.dump_start = 1'b1;
                state_nxt      = S_DRD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_STAT: begin
        if (stat.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_status = stat_code_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_POUT: begin
        if (stat.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_status = dq_pkg::ST_OK;
          cmd.use_data   = 1'b1;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DRD: begin
        cmd.dump_read = 1'b1;
        state_nxt     = S_DOUT;
      end
      S_DOUT: begin
        if (stat.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_status = dq_pkg::ST_OK;
          cmd.use_data   = 1'b1;
          cmd.out_last   = stat.dump_last;
          cmd.dump_step  = 1'b1;
          state_nxt      = stat.dump_last ? S_IDLE : S_DRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/dq_datapath.sv */
// ----------------------------------------------------------------------------
// dq_datapath - ring buffer storage, pointers and result register
// Holds the entry memory, front index, count, dump walker and output word.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [dq_pkg::VALUE_W-1:0] in_value,
  input  dq_pkg::dq_cmd_t                   cmd,
  output dq_pkg::dq_stat_t                  stat,
  dq_out_if.source                          out_ch
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  logic [dq_pkg::VALUE_W-1:0] mem_r [DEPTH];
  logic [dq_pkg::VALUE_W-1:0] rd_data_r;

  logic [IW-1:0] front_r, front_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] dptr_r, dptr_nxt;
  logic [CW-1:0] rem_r, rem_nxt;

  logic                              out_valid_r;
  dq_pkg::status_t                   out_status_r;
  logic signed [dq_pkg::VALUE_W-1:0] out_value_r;
  logic                              out_last_r;
  logic [dq_pkg::COUNT_W-1:0]        out_count_r;

  logic [IW-1:0] front_dec, front_inc, dptr_inc, tail_pos, back_pos;
  logic [SW-1:0] sum_tail, sum_back;
  logic [IW-1:0] wr_addr, rd_addr;
  logic          wr_en, rd_en;
  logic [CW+dq_pkg::COUNT_W-1:0] cnt_ext;

  always_comb begin
    front_dec = (front_r == '0) ? LAST_IDX : front_r - 1'b1;
    front_inc = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
    dptr_inc  = (dptr_r == LAST_IDX) ? '0 : dptr_r + 1'b1;
    sum_tail  = {1'b0, front_r} + SW'(count_r);
    sum_back  = sum_tail - 1'b1;
    tail_pos  = (sum_tail >= DEPTH_S) ? IW'(sum_tail - DEPTH_S) : sum_tail[IW-1:0];
    back_pos  = (sum_back >= DEPTH_S) ? IW'(sum_back - DEPTH_S) : sum_back[IW-1:0];
  end

  assign wr_en   = cmd.push_front | cmd.push_back;
  assign wr_addr = cmd.push_front ? front_dec : tail_pos;
  assign rd_en   = cmd.pop_front | cmd.pop_back | cmd.dump_read;
  assign rd_addr = cmd.pop_front ? front_r : (cmd.pop_back ? back_pos : dptr_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= in_value;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    dptr_nxt  = dptr_r;
    rem_nxt   = rem_r;
    if (cmd.push_front) begin
      front_nxt = front_dec;
    end
    if (cmd.pop_front) begin
      front_nxt = front_inc;
    end
    if (wr_en) begin
      count_nxt = count_r + 1'b1;
    end
    if (cmd.pop_front || cmd.pop_back) begin
      count_nxt = count_r - 1'b1;
    end
    if (cmd.dump_start) begin
      dptr_nxt = front_r;
      rem_nxt  = count_r;
    end
    if (cmd.dump_step) begin
      dptr_nxt = dptr_inc;
      rem_nxt  = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
      dptr_r  <= '0;
      rem_r   <= '0;
    end else begin
      front_r <= front_nxt;
      count_r <= count_nxt;
      dptr_r  <= dptr_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign cnt_ext = {{dq_pkg::COUNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= cmd.out_status;
      out_value_r  <= cmd.use_data ? rd_data_r : '0;
      out_last_r   <= cmd.out_last;
      out_count_r  <= cnt_ext[dq_pkg::COUNT_W-1:0];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.count     = out_count_r;

  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == DEPTH_C);
  assign stat.out_free  = !out_valid_r || out_ch.ready;
  assign stat.dump_last = (rem_r == CW'(1));

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("stored count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    front_r <= LAST_IDX)
    else $error("front index out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ch.ready))
    else $error("result word overwritten before taken");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_front || cmd.push_back) |-> (count_r != DEPTH_C))
    else $error("push into full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_front || cmd.pop_back || cmd.dump_start) |-> (count_r != '0))
    else $error("read from empty queue");

  a_dump_rem: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.dump_read |-> (rem_r != '0 && rem_r <= count_r))
    else $error("dump walker out of range");

endmodule

/* sv/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_queue - bounded deque of signed 32-bit words
// Push/pop at either end plus a front-to-back dump, on a ring buffer.
// ----------------------------------------------------------------------------
// Each request word carries an action: push front, push back, pop front, pop
// back or dump; codes five to seven are taken and dropped without a result.
// A push or pop gives one result word. The block accepts the request and
// touches the entry memory, then loads the result register once it is free,
// and takes no new request until that is done. In a dump, each stored word
// goes through the memory's registered read before it is loaded into the
// result register. A request is taken only while the sequencer is idle; a
// finished result may still be waiting in the result register at that time.
// DEPTH sets the capacity (2 to 64); count is reported in its low six bits.
module double_ended_queue #(
  parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  dq_in_if.sink    in_ch,
  dq_out_if.source out_ch
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;
  logic             in_ready;

  assign in_ch.ready = in_ready;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_ch.value),
    .cmd      (cmd),
    .stat     (stat),
    .out_ch   (out_ch)
  );

endmodule

/* verif/double_ended_queue_tb.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_tb - self-checking bench for the double-ended queue
// Directed words hit the empty, full and wrap-around corners and the unused
// action codes. Random fill/drain runs and a random mix follow. A local deque
// model predicts every result word, and a monitor checks each one in order.
// Both sides idle and stall in random bursts, except in the last part.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;

  localparam int DEPTH      = dq_pkg::DEPTH_DEF;
  localparam int MAX_SHOWN  = 10;
  localparam int DRAIN_WAIT = 20000;
  localparam int SETTLE     = 2 * DEPTH + 8;

  localparam dq_pkg::action_t ACT_RSVD_FIRST = 3'd5;
  localparam dq_pkg::action_t ACT_RSVD_LAST  = 3'd7;

  localparam logic signed [dq_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [dq_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef struct {
    dq_pkg::status_t                   status;
    logic signed [dq_pkg::VALUE_W-1:0] value;
    logic                              last;
    logic [dq_pkg::COUNT_W-1:0]        count;
  } result_word_t;

  logic clk;
  logic rst_n;

  dq_in_if  req_if ();
  dq_out_if rsp_if ();

  double_ended_queue #(.DEPTH(DEPTH)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_if),
    .out_ch(rsp_if)
  );

  // deque model state
  logic signed [dq_pkg::VALUE_W-1:0] ring [DEPTH];
  int head_idx;
  int fill_level;
  result_word_t words_due [$];

  int  mismatches;
  int  words_in;
  int  words_out;
  int  full_seen;
  int  empty_seen;
  int  longest_dump;
  bit  req_gaps_on;
  bit  rsp_stalls_on;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic void expect_word(dq_pkg::status_t st,
                                      logic signed [dq_pkg::VALUE_W-1:0] v,
                                      logic lst);
    result_word_t w;
    w.status = st;
    w.value  = v;
    w.last   = lst;
    w.count  = dq_pkg::COUNT_W'(fill_level);
    words_due.push_back(w);
  endfunction

  function automatic void apply_action(dq_pkg::action_t act,
                                       logic signed [dq_pkg::VALUE_W-1:0] v);
    int pos;
    case (act)
      dq_pkg::ACT_PUSH_FRONT, dq_pkg::ACT_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          expect_word(dq_pkg::ST_FULL, '0, 1'b1);
        end else begin
          if (act == dq_pkg::ACT_PUSH_FRONT) begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            pos = head_idx;
          end else begin
            pos = (head_idx + fill_level) % DEPTH;
          end
          ring[pos] = v;
          fill_level++;
          expect_word(dq_pkg::ST_OK, '0, 1'b1);
        end
      end
      dq_pkg::ACT_POP_FRONT, dq_pkg::ACT_POP_BACK: begin
        if (fill_level == 0) begin
          expect_word(dq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          if (act == dq_pkg::ACT_POP_FRONT) begin
            pos = head_idx;
            head_idx = (head_idx + 1) % DEPTH;
          end else begin
            pos = (head_idx + fill_level - 1) % DEPTH;
          end
          fill_level--;
          expect_word(dq_pkg::ST_OK, ring[pos], 1'b1);
        end
      end
      dq_pkg::ACT_DUMP: begin
        if (fill_level == 0) begin
          expect_word(dq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          if (fill_level > longest_dump) longest_dump = fill_level;
          for (int i = 0; i < fill_level; i++)
            expect_word(dq_pkg::ST_OK, ring[(head_idx + i) % DEPTH],
                        i == fill_level - 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("MISMATCH: %s", msg);
  endfunction

  // result monitor
  always @(posedge clk) begin : check_result
    result_word_t want;
    if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      words_out++;
      if (rsp_if.status == dq_pkg::ST_FULL) full_seen++;
      if (rsp_if.status == dq_pkg::ST_EMPTY) empty_seen++;
      if (words_due.size() == 0) begin
        note_mismatch($sformatf(
          "result word with nothing due: status=%0d value=%0d last=%0b count=%0d",
          rsp_if.status, rsp_if.value_res, rsp_if.last, rsp_if.count));
      end else begin
        want = words_due.pop_front();
        if (rsp_if.status !== want.status || rsp_if.value_res !== want.value ||
            rsp_if.last !== want.last || rsp_if.count !== want.count)
          note_mismatch($sformatf(
            {"word %0d exp status=%0d value=%0d last=%0b count=%0d",
             " got status=%0d value=%0d last=%0b count=%0d"},
            words_out, want.status, want.value, want.last, want.count,
            rsp_if.status, rsp_if.value_res, rsp_if.last, rsp_if.count));
      end
    end
  end

  // result-side backpressure
  initial begin
    forever begin
      if (rsp_stalls_on && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [dq_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic dq_pkg::action_t rand_unused();
    return dq_pkg::action_t'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
  endfunction

  task automatic send_word(dq_pkg::action_t act, logic signed [dq_pkg::VALUE_W-1:0] v);
    if (req_gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.value  <= v;
    @(posedge clk);
    while (req_if.ready !== 1'b1) @(posedge clk);
    words_in++;
    apply_action(act, v);
  endtask

  task automatic wait_all_results();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (words_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    send_word(dq_pkg::ACT_POP_FRONT, $urandom);
    send_word(dq_pkg::ACT_POP_BACK, $urandom);
    send_word(dq_pkg::ACT_DUMP, $urandom);
    send_word(ACT_RSVD_FIRST, VAL_MAX);
    send_word(dq_pkg::action_t'(ACT_RSVD_FIRST + 1), VAL_MIN);
    send_word(ACT_RSVD_LAST, $urandom);
  endtask

  task automatic test_end_values();
    send_word(dq_pkg::ACT_PUSH_FRONT, VAL_MAX);   // head wraps below zero
    send_word(dq_pkg::ACT_PUSH_BACK, VAL_MIN);
    send_word(dq_pkg::ACT_PUSH_FRONT, '0);
    send_word(dq_pkg::ACT_PUSH_BACK, -1);
    send_word(rand_unused(), $urandom);
    send_word(dq_pkg::ACT_DUMP, '0);
    send_word(dq_pkg::ACT_POP_BACK, '0);
    send_word(dq_pkg::ACT_POP_FRONT, '0);
    send_word(dq_pkg::ACT_POP_FRONT, '0);
    send_word(dq_pkg::ACT_POP_BACK, '0);
    send_word(dq_pkg::ACT_POP_FRONT, '0);
  endtask

  task automatic test_fill_and_drain();
    while (fill_level < DEPTH)
      send_word($urandom_range(0, 1) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT,
                rand_value());
    send_word(dq_pkg::ACT_PUSH_FRONT, rand_value());
    send_word(dq_pkg::ACT_PUSH_BACK, rand_value());
    wait_all_results();
    send_word(dq_pkg::ACT_DUMP, rand_value());
    while (fill_level > 0)
      send_word($urandom_range(0, 1) ? dq_pkg::ACT_POP_BACK : dq_pkg::ACT_POP_FRONT,
                rand_value());
    send_word(dq_pkg::ACT_DUMP, rand_value());
  endtask

  task automatic test_random_mix(int n_words);
    int sent;
    int pick;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_word($urandom_range(0, 1) ? dq_pkg::ACT_PUSH_BACK : dq_pkg::ACT_PUSH_FRONT,
                  rand_value());
        sent++;
      end else if (pick < 85) begin
        send_word($urandom_range(0, 1) ? dq_pkg::ACT_POP_BACK : dq_pkg::ACT_POP_FRONT,
                  rand_value());
        sent++;
      end else if (pick < 95) begin
        send_word(dq_pkg::ACT_DUMP, rand_value());
        sent++;
      end else begin
        send_word(rand_unused(), rand_value());
      end
    end
  endtask

  task automatic test_back_to_back();
    req_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    test_random_mix(12);
  endtask

  task automatic finish_run();
    int waited;
    req_if.valid <= 1'b0;
    waited = 0;
    while (words_due.size() != 0 && waited < DRAIN_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (words_due.size() != 0)
      note_mismatch($sformatf("%0d result words never arrived", words_due.size()));
    $display("covered %0d request words and %0d result words, longest dump %0d words",
             words_in, words_out, longest_dump);
    $display("seen %0d full and %0d empty answers", full_seen, empty_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  endtask

  initial begin
    head_idx      = 0;
    fill_level    = 0;
    mismatches    = 0;
    words_in      = 0;
    words_out     = 0;
    full_seen     = 0;
    empty_seen    = 0;
    longest_dump  = 0;
    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    rst_n         <= 1'b0;
    req_if.valid  <= 1'b0;
    req_if.action <= dq_pkg::ACT_PUSH_FRONT;
    req_if.value  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_end_values();
    test_fill_and_drain();
    test_random_mix(12);
    test_back_to_back();
    finish_run();
  end

endmodule
